// ----- hw/rtl/aeti_pkg.sv -----
// aeti_pkg: shared types, character codes and colour helpers for the ansi text importer
// used by aeti_core and ansi_escape_text_importer; no dependencies

package aeti_pkg;

    localparam int LINE_WIDTH_DEF  = 80;
    localparam int COORD_BITS_DEF  = 12;
    localparam int NUMBER_BITS_DEF = 16;

    localparam int CFG_COORD_W = 12;
    localparam int CFG_SIZE_W  = 13;
    localparam int OUT_COORD_W = 12;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int OUT_DATA_W  = 40;

    localparam logic [CFG_COORD_W-1:0] START_COL_RST    = 12'd0;
    localparam logic [CFG_COORD_W-1:0] START_ROW_RST    = 12'd0;
    localparam logic [CFG_SIZE_W-1:0]  BOARD_WIDTH_RST  = 13'd80;
    localparam logic [CFG_SIZE_W-1:0]  BOARD_HEIGHT_RST = 13'd25;

    localparam logic [7:0] CHAR_ESC    = 8'h1B;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_LBRACK = 8'h5B;
    localparam logic [7:0] CHAR_SEMI   = 8'h3B;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_SAVE   = 8'h73;
    localparam logic [7:0] CHAR_REST   = 8'h75;
    localparam logic [7:0] CHAR_ERASE  = 8'h4B;
    localparam logic [7:0] CHAR_UP     = 8'h41;
    localparam logic [7:0] CHAR_DOWN   = 8'h42;
    localparam logic [7:0] CHAR_RIGHT  = 8'h43;
    localparam logic [7:0] CHAR_LEFT   = 8'h44;
    localparam logic [7:0] CHAR_HOME   = 8'h48;
    localparam logic [7:0] CHAR_CLEAR  = 8'h4A;
    localparam logic [7:0] CHAR_SGR    = 8'h6D;

    localparam logic [7:0] COLOUR_RST   = 8'd7;
    localparam logic [7:0] FG_KEEP      = 8'd248;
    localparam logic [7:0] BG_KEEP      = 8'd143;
    localparam logic [7:0] BRIGHT_BIT   = 8'd8;
    localparam logic [7:0] BLINK_BIT    = 8'd128;

    localparam logic [31:0] SGR_RESET  = 32'd0;
    localparam logic [31:0] SGR_BRIGHT = 32'd1;
    localparam logic [31:0] SGR_BLINK  = 32'd5;
    localparam logic [31:0] SGR_FG_LO  = 32'd30;
    localparam logic [31:0] SGR_FG_HI  = 32'd37;
    localparam logic [31:0] SGR_BG_LO  = 32'd40;
    localparam logic [31:0] SGR_BG_HI  = 32'd47;
    localparam logic [31:0] CLEAR_ALL  = 32'd2;

    localparam logic KIND_CELL = 1'b0;
    localparam logic KIND_STOP = 1'b1;

    typedef enum logic [2:0] {
        PH_TEXT,
        PH_ESC,
        PH_CSI,
        PH_NUM,
        PH_STOP
    } phase_t;

    typedef enum logic [1:0] {
        REG_START_COL,
        REG_START_ROW,
        REG_BOARD_WIDTH,
        REG_BOARD_HEIGHT
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_COORD_W-1:0] start_col;
        logic [CFG_COORD_W-1:0] start_row;
        logic [CFG_SIZE_W-1:0]  board_width;
        logic [CFG_SIZE_W-1:0]  board_height;
    } cfg_t;

    typedef struct packed {
        logic                   kind;
        logic [7:0]             attribute;
        logic [7:0]             symbol;
        logic [OUT_COORD_W-1:0] cell_row;
        logic [OUT_COORD_W-1:0] cell_col;
    } res_t;

    // ansi colour order to board colour order
    function automatic logic [2:0] ega_colour(input logic [2:0] a);
        logic [2:0] r;
        case (a)
            3'd0: r = 3'd0;
            3'd1: r = 3'd4;
            3'd2: r = 3'd2;
            3'd3: r = 3'd6;
            3'd4: r = 3'd1;
            3'd5: r = 3'd5;
            3'd6: r = 3'd3;
            3'd7: r = 3'd7;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] apply_sgr(input logic [7:0] c, input logic [31:0] code);
        logic [7:0]  r;
        logic [31:0] off;
        r   = c;
        off = 32'd0;
        if (code == SGR_RESET) begin
            r = COLOUR_RST;
        end else if (code == SGR_BRIGHT) begin
            r = c | BRIGHT_BIT;
        end else if (code == SGR_BLINK) begin
            r = c | BLINK_BIT;
        end else if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
            off = code - SGR_FG_LO;
            r   = (c & FG_KEEP) + {5'd0, ega_colour(off[2:0])};
        end else if (code >= SGR_BG_LO && code <= SGR_BG_HI) begin
            off = code - SGR_BG_LO;
            r   = (c & BG_KEEP) + {1'b0, ega_colour(off[2:0]), 4'd0};
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/aeti_core.sv -----
// aeti_core: escape parser state, cursor and colour update for one byte per cycle
// while step is high; depends on aeti_pkg

module aeti_core
    import aeti_pkg::*;
#(
    parameter int LINE_WIDTH  = LINE_WIDTH_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] byte_in,
    input  logic       first,
    input  cfg_t       cfg,
    output logic       res_valid,
    output res_t       res
);

    localparam int BASE_W = (NUMBER_BITS > COORD_BITS + 1) ? NUMBER_BITS : COORD_BITS + 1;
    localparam int CW     = ((BASE_W > 14) ? BASE_W : 14) + 2;

    localparam logic signed [CW-1:0] ONE      = CW'(1);
    localparam logic signed [CW-1:0] SIZE_LIM = CW'(64'd1 << COORD_BITS);
    localparam logic signed [CW-1:0] LW_M1    = CW'(LINE_WIDTH - 1);
    localparam logic [NUMBER_BITS-1:0] NUM_MAX = {NUMBER_BITS{1'b1}};
    localparam logic [NUMBER_BITS+3:0] NUM_MAX_W = (NUMBER_BITS+4)'(NUM_MAX);

    function automatic logic signed [CW-1:0] clamp_col(input logic signed [CW-1:0] x,
                                                      input logic signed [CW-1:0] sc,
                                                      input logic signed [CW-1:0] bw);
        logic signed [CW-1:0] r;
        r = x;
        if (r > sc + LW_M1) r = sc + LW_M1;
        if (r >= bw) r = bw - ONE;
        return r;
    endfunction

    function automatic logic signed [CW-1:0] clamp_row(input logic signed [CW-1:0] y,
                                                      input logic signed [CW-1:0] bh);
        logic signed [CW-1:0] r;
        r = y;
        if (r >= bh) r = bh - ONE;
        return r;
    endfunction

    function automatic logic [COORD_BITS-1:0] to_coord(input logic signed [CW-1:0] v);
        logic [COORD_BITS-1:0] r;
        r = (v < 0) ? '0 : v[COORD_BITS-1:0];
        return r;
    endfunction

    logic [COORD_BITS-1:0]  cur_col_reg, cur_col_next;
    logic [COORD_BITS-1:0]  cur_row_reg, cur_row_next;
    logic [COORD_BITS-1:0]  sav_col_reg, sav_col_next;
    logic [COORD_BITS-1:0]  sav_row_reg, sav_row_next;
    logic [7:0]             colour_reg, colour_next;
    phase_t                 phase_reg, phase_next;
    logic [NUMBER_BITS-1:0] number_reg, number_next;
    logic [NUMBER_BITS-1:0] held_reg, held_next;
    logic                   held_valid_reg, held_valid_next;

    // state as seen after an optional restart
    logic [COORD_BITS-1:0]  p_col, p_row, p_scol, p_srow;
    logic [7:0]             p_colour;
    phase_t                 p_phase;
    logic [NUMBER_BITS-1:0] p_num, p_held;
    logic                   p_hv;
    logic [COORD_BITS-1:0]  home_col, home_row;

    logic signed [CW-1:0] sc, sr, bw, bh, bw_raw, bh_raw;
    logic signed [CW-1:0] cc_s, cr_s, num_s, held_s, mv_n;
    logic signed [CW-1:0] row_inc, pl_x, pl_x1, pl_x2, pl_y1, ux;
    logic                 wrap;
    logic signed [CW-1:0] mv_up, mv_down, mv_right, mv_left;
    logic signed [CW-1:0] hx, hy, hx_c, hy_c;
    logic [NUMBER_BITS+3:0] acc;
    logic [NUMBER_BITS-1:0] acc_sat, dig_num;
    logic [3:0]             dval;
    logic                   digit, is_move, do_plain;
    logic [7:0]             sgr_held, sgr_both;

    assign home_col = COORD_BITS'(cfg.start_col);
    assign home_row = COORD_BITS'(cfg.start_row);

    assign p_col    = first ? home_col : cur_col_reg;
    assign p_row    = first ? home_row : cur_row_reg;
    assign p_scol   = first ? home_col : sav_col_reg;
    assign p_srow   = first ? home_row : sav_row_reg;
    assign p_colour = first ? COLOUR_RST : colour_reg;
    assign p_phase  = first ? PH_TEXT : phase_reg;
    assign p_num    = first ? '0 : number_reg;
    assign p_held   = first ? '0 : held_reg;
    assign p_hv     = first ? 1'b0 : held_valid_reg;

    assign sc     = $signed(CW'(cfg.start_col));
    assign sr     = $signed(CW'(cfg.start_row));
    assign bw_raw = $signed(CW'(cfg.board_width));
    assign bh_raw = $signed(CW'(cfg.board_height));
    assign bw     = (bw_raw == 0) ? ONE : ((bw_raw > SIZE_LIM) ? SIZE_LIM : bw_raw);
    assign bh     = (bh_raw == 0) ? ONE : ((bh_raw > SIZE_LIM) ? SIZE_LIM : bh_raw);

    assign cc_s   = $signed(CW'(p_col));
    assign cr_s   = $signed(CW'(p_row));
    assign num_s  = $signed(CW'(p_num));
    assign held_s = $signed(CW'(p_held));

    assign digit   = (byte_in >= CHAR_ZERO) && (byte_in <= CHAR_NINE);
    assign dval    = 4'(byte_in - CHAR_ZERO);
    assign is_move = (byte_in == CHAR_UP) || (byte_in == CHAR_DOWN) ||
                     (byte_in == CHAR_RIGHT) || (byte_in == CHAR_LEFT);

    // plain text: cell write and cursor advance
    assign row_inc = clamp_row(cr_s + ONE, bh);
    assign pl_x    = cc_s + ONE;
    assign wrap    = pl_x > sc + LW_M1;
    assign pl_x1   = wrap ? sc : pl_x;
    assign pl_y1   = wrap ? row_inc : cr_s;
    assign pl_x2   = (pl_x1 >= bw) ? bw - ONE : pl_x1;
    assign ux      = (cc_s >= bw) ? bw - ONE : cc_s;

    // relative moves
    assign mv_n     = (p_phase == PH_CSI) ? ONE : num_s;
    assign mv_up    = (cr_s - mv_n < sr) ? sr : cr_s - mv_n;
    assign mv_down  = clamp_row(cr_s + mv_n, bh);
    assign mv_right = clamp_col(cc_s + mv_n, sc, bw);
    assign mv_left  = (cc_s - mv_n < sc) ? sc : cc_s - mv_n;

    // absolute position
    assign hy   = p_hv ? sr + held_s - ONE : sr + num_s - ONE;
    assign hx   = p_hv ? sc + num_s - ONE : sc;
    assign hx_c = (clamp_col(hx, sc, bw) < sc) ? sc : clamp_col(hx, sc, bw);
    assign hy_c = (clamp_row(hy, bh) < sr) ? sr : clamp_row(hy, bh);

    // decimal accumulate with saturation
    assign acc     = (NUMBER_BITS+4)'(p_num) * (NUMBER_BITS+4)'(10)
                   + (NUMBER_BITS+4)'(dval);
    assign acc_sat = (acc > NUM_MAX_W) ? NUM_MAX : acc[NUMBER_BITS-1:0];
    assign dig_num = NUMBER_BITS'(dval);

    assign sgr_held = p_hv ? apply_sgr(p_colour, 32'(p_held)) : p_colour;
    assign sgr_both = apply_sgr(sgr_held, 32'(p_num));

    always_comb begin
        cur_col_next    = p_col;
        cur_row_next    = p_row;
        sav_col_next    = p_scol;
        sav_row_next    = p_srow;
        colour_next     = p_colour;
        phase_next      = p_phase;
        number_next     = p_num;
        held_next       = p_held;
        held_valid_next = p_hv;
        res_valid       = 1'b0;
        res             = '0;
        do_plain        = 1'b0;

        case (p_phase)
            PH_TEXT: begin
                if (byte_in == CHAR_ESC) begin
                    phase_next = PH_ESC;
                end else begin
                    do_plain = 1'b1;
                end
            end
            PH_ESC: begin
                if (byte_in == CHAR_LBRACK) begin
                    phase_next      = PH_CSI;
                    held_valid_next = 1'b0;
                    held_next       = '0;
                    number_next     = '0;
                end else begin
                    do_plain = 1'b1;
                end
            end
            PH_CSI: begin
                phase_next = PH_TEXT;
                if (byte_in == CHAR_SAVE) begin
                    sav_col_next = p_col;
                    sav_row_next = p_row;
                end else if (byte_in == CHAR_REST) begin
                    cur_col_next = p_scol;
                    cur_row_next = p_srow;
                end else if (byte_in == CHAR_ERASE) begin
                    phase_next = PH_TEXT;
                end else if (is_move) begin
                    cur_col_next = (byte_in == CHAR_RIGHT) ? to_coord(mv_right) :
                                   (byte_in == CHAR_LEFT)  ? to_coord(mv_left) : p_col;
                    cur_row_next = (byte_in == CHAR_UP)    ? to_coord(mv_up) :
                                   (byte_in == CHAR_DOWN)  ? to_coord(mv_down) : p_row;
                end else if (byte_in == CHAR_HOME) begin
                    cur_col_next = home_col;
                    cur_row_next = home_row;
                end else if (digit) begin
                    number_next = dig_num;
                    phase_next  = PH_NUM;
                end else begin
                    do_plain = 1'b1;
                end
            end
            PH_NUM: begin
                if (digit) begin
                    number_next = acc_sat;
                end else begin
                    phase_next = PH_TEXT;
                    if (byte_in == CHAR_CLEAR) begin
                        if (32'(p_num) != CLEAR_ALL) begin
                            phase_next = PH_STOP;
                            res_valid  = 1'b1;
                            res.kind   = KIND_STOP;
                        end else begin
                            cur_col_next = home_col;
                            cur_row_next = home_row;
                        end
                    end else if (is_move) begin
                        cur_col_next = (byte_in == CHAR_RIGHT) ? to_coord(mv_right) :
                                       (byte_in == CHAR_LEFT)  ? to_coord(mv_left) : p_col;
                        cur_row_next = (byte_in == CHAR_UP)    ? to_coord(mv_up) :
                                       (byte_in == CHAR_DOWN)  ? to_coord(mv_down) : p_row;
                    end else if (byte_in == CHAR_ERASE) begin
                        phase_next = PH_TEXT;
                    end else if (byte_in == CHAR_HOME) begin
                        cur_col_next    = to_coord(hx_c);
                        cur_row_next    = to_coord(hy_c);
                        held_valid_next = 1'b0;
                    end else if (byte_in == CHAR_SEMI) begin
                        colour_next     = sgr_held;
                        held_next       = p_num;
                        held_valid_next = 1'b1;
                        number_next     = '0;
                        phase_next      = PH_NUM;
                    end else if (byte_in == CHAR_SGR) begin
                        colour_next = sgr_both;
                    end else begin
                        do_plain = 1'b1;
                    end
                end
            end
            PH_STOP: begin
                phase_next = PH_STOP;
            end
            default: begin
                phase_next = PH_TEXT;
            end
        endcase

        if (do_plain) begin
            phase_next = PH_TEXT;
            if (byte_in == CHAR_CR) begin
                cur_col_next = home_col;
            end else if (byte_in == CHAR_LF) begin
                cur_row_next = to_coord(row_inc);
            end else begin
                res_valid     = 1'b1;
                res.kind      = KIND_CELL;
                res.cell_col  = ux[OUT_COORD_W-1:0];
                res.cell_row  = cr_s[OUT_COORD_W-1:0];
                res.symbol    = byte_in;
                res.attribute = p_colour;
                cur_col_next  = to_coord(pl_x2);
                cur_row_next  = to_coord(pl_y1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            sav_col_reg    <= '0;
            sav_row_reg    <= '0;
            colour_reg     <= COLOUR_RST;
            phase_reg      <= PH_TEXT;
            number_reg     <= '0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
        end else if (step) begin
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            sav_col_reg    <= sav_col_next;
            sav_row_reg    <= sav_row_next;
            colour_reg     <= colour_next;
            phase_reg      <= phase_next;
            number_reg     <= number_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
        end
    end

endmodule

// ----- hw/rtl/ansi_escape_text_importer.sv -----
// ansi_escape_text_importer: a byte stream of ansi text in, board cell writes out
// depends on aeti_pkg and aeti_core
//
// One byte is taken per transfer and the block sustains one transfer per clock while
// the output side does not stall; a byte is held in an input register, decoded
// combinationally against the parser and cursor state, and its cell write or stop marker
// lands in the output register. s_tready falls only while the output
// register holds a result that m_tready has not taken. Bytes that only move the cursor,
// change colour or belong to an escape sequence give no transfer on the output side.
// After ESC[nJ with n other than 2 the block gives a stop marker and then ignores bytes
// until one arrives with the first flag set. The window and board size are set through
// the apb port and are to be written only while the block is idle.

module ansi_escape_text_importer
    import aeti_pkg::*;
#(
    parameter int LINE_WIDTH  = LINE_WIDTH_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // byte_in
    input  logic                  s_tuser,   // first

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // cell_col, cell_row, symbol, attribute
    output logic                  m_tuser    // kind
);

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic       out_valid_reg;
    res_t       out_reg;

    logic       advance;
    logic       core_valid;
    res_t       core_res;
    reg_idx_t   reg_idx;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_col    <= START_COL_RST;
            cfg_reg.start_row    <= START_ROW_RST;
            cfg_reg.board_width  <= BOARD_WIDTH_RST;
            cfg_reg.board_height <= BOARD_HEIGHT_RST;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_START_COL:    cfg_reg.start_col    <= pwdata[CFG_COORD_W-1:0];
                REG_START_ROW:    cfg_reg.start_row    <= pwdata[CFG_COORD_W-1:0];
                REG_BOARD_WIDTH:  cfg_reg.board_width  <= pwdata[CFG_SIZE_W-1:0];
                REG_BOARD_HEIGHT: cfg_reg.board_height <= pwdata[CFG_SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_START_COL:    prdata = APB_DATA_W'(cfg_reg.start_col);
            REG_START_ROW:    prdata = APB_DATA_W'(cfg_reg.start_row);
            REG_BOARD_WIDTH:  prdata = APB_DATA_W'(cfg_reg.board_width);
            REG_BOARD_HEIGHT: prdata = APB_DATA_W'(cfg_reg.board_height);
            default:          prdata = '0;
        endcase
    end

    // input stage moves on when the output register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
        end
    end

    aeti_core #(
        .LINE_WIDTH  (LINE_WIDTH),
        .COORD_BITS  (COORD_BITS),
        .NUMBER_BITS (NUMBER_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .byte_in   (in_byte_reg),
        .first     (in_first_reg),
        .cfg       (cfg_reg),
        .res_valid (core_valid),
        .res       (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= core_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && core_valid) begin
            out_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {out_reg.attribute, out_reg.symbol, out_reg.cell_row, out_reg.cell_col};

`ifndef SYNTHESIS
    a_stop_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_STOP) |-> (m_tdata == '0))
        else $error("stop marker carries nonzero cell fields");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_valid_reg) |-> s_tready)
        else $error("input stalled with an empty output register");

    a_result_needs_input: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(out_valid_reg)) |-> $past(in_valid_reg))
        else $error("result produced without a byte in the input register");
`endif

endmodule

// ----- bench/aeti_tb_pkg.sv -----
// cell write tracker for the ansi text importer bench: mirrors the parser and cursor
// state per accepted byte and holds the cell writes and stop markers still due
// depends on aeti_pkg
`timescale 1ns / 100ps

package aeti_tb_pkg;
    import aeti_pkg::*;

    class cell_write_tracker;
        int unsigned start_col, start_row, board_width, board_height;
        int          cur_col, cur_row, sav_col, sav_row;
        logic [7:0]  colour;
        phase_t      phase;
        int unsigned number, held_param;
        bit          held_valid;
        bit [2:0]    ega_map [8];
        res_t        pending_cells[$];
        int          errors;

        function new();
            ega_map      = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};
            start_col    = START_COL_RST;
            start_row    = START_ROW_RST;
            board_width  = BOARD_WIDTH_RST;
            board_height = BOARD_HEIGHT_RST;
            errors       = 0;
            restart();
        endfunction

        function void set_reg(input reg_idx_t idx, input int unsigned val);
            case (idx)
                REG_START_COL:    start_col    = val & ((1 << CFG_COORD_W) - 1);
                REG_START_ROW:    start_row    = val & ((1 << CFG_COORD_W) - 1);
                REG_BOARD_WIDTH:  board_width  = val & ((1 << CFG_SIZE_W) - 1);
                REG_BOARD_HEIGHT: board_height = val & ((1 << CFG_SIZE_W) - 1);
                default: ;
            endcase
        endfunction

        function int eff_size(input int unsigned v);
            if (v == 0) return 1;
            if (v > (1 << COORD_BITS_DEF)) return 1 << COORD_BITS_DEF;
            return int'(v);
        endfunction

        function int to_coord(input int v);
            if (v < 0) v = 0;
            return v & ((1 << COORD_BITS_DEF) - 1);
        endfunction

        function void restart();
            cur_col    = to_coord(int'(start_col));
            cur_row    = to_coord(int'(start_row));
            sav_col    = cur_col;
            sav_row    = cur_row;
            colour     = COLOUR_RST;
            phase      = PH_TEXT;
            number     = 0;
            held_param = 0;
            held_valid = 0;
        endfunction

        function int clamp_col_high(input int x);
            int bw;
            bw = eff_size(board_width);
            if (x > int'(start_col) + LINE_WIDTH_DEF - 1) x = int'(start_col) + LINE_WIDTH_DEF - 1;
            if (x >= bw) x = bw - 1;
            return x;
        endfunction

        function int clamp_row_high(input int y);
            int bh;
            bh = eff_size(board_height);
            if (y >= bh) y = bh - 1;
            return y;
        endfunction

        function void sgr_update(input int unsigned code);
            logic [7:0] c;
            c = colour;
            if (code == 0) c = COLOUR_RST;
            else if (code == 1) c = c | BRIGHT_BIT;
            else if (code == 5) c = c | BLINK_BIT;
            else if (code >= 30 && code <= 37) c = (c & FG_KEEP) + {5'd0, ega_map[code - 30]};
            else if (code >= 40 && code <= 47) c = (c & BG_KEEP) + {1'b0, ega_map[code - 40], 4'd0};
            colour = c;
        endfunction

        function void move_cursor(input logic [7:0] dir, input int n);
            int x, y;
            x = cur_col;
            y = cur_row;
            if (dir == CHAR_UP) begin
                y = y - n;
                if (y < int'(start_row)) y = int'(start_row);
            end else if (dir == CHAR_DOWN) begin
                y = clamp_row_high(y + n);
            end else if (dir == CHAR_RIGHT) begin
                x = clamp_col_high(x + n);
            end else begin
                x = x - n;
                if (x < int'(start_col)) x = int'(start_col);
            end
            cur_col = to_coord(x);
            cur_row = to_coord(y);
        endfunction

        function bit plain(input logic [7:0] b, output res_t r);
            int x, y, bw, ux;
            x     = cur_col;
            y     = cur_row;
            bw    = eff_size(board_width);
            r     = '0;
            phase = PH_TEXT;
            if (b == CHAR_CR) begin
                cur_col = to_coord(int'(start_col));
                return 0;
            end
            if (b == CHAR_LF) begin
                cur_row = to_coord(clamp_row_high(y + 1));
                return 0;
            end
            ux = (x >= bw) ? bw - 1 : x;
            r.kind      = KIND_CELL;
            r.cell_col  = ux[OUT_COORD_W-1:0];
            r.cell_row  = y[OUT_COORD_W-1:0];
            r.symbol    = b;
            r.attribute = colour;
            x++;
            if (x > int'(start_col) + LINE_WIDTH_DEF - 1) begin
                x = int'(start_col);
                y = clamp_row_high(y + 1);
            end
            if (x >= bw) x = bw - 1;
            cur_col = to_coord(x);
            cur_row = to_coord(y);
            return 1;
        endfunction

        function bit end_number(input logic [7:0] b, output res_t r);
            int n, x, y;
            n     = int'(number);
            r     = '0;
            phase = PH_TEXT;
            if (b == CHAR_CLEAR) begin
                if (number != CLEAR_ALL) begin
                    phase  = PH_STOP;
                    r.kind = KIND_STOP;
                    return 1;
                end
                cur_col = to_coord(int'(start_col));
                cur_row = to_coord(int'(start_row));
                return 0;
            end
            if (b == CHAR_UP || b == CHAR_DOWN || b == CHAR_RIGHT || b == CHAR_LEFT) begin
                move_cursor(b, n);
                return 0;
            end
            if (b == CHAR_ERASE) return 0;
            if (b == CHAR_HOME) begin
                if (held_valid) begin
                    y = int'(start_row) + int'(held_param) - 1;
                    x = int'(start_col) + n - 1;
                end else begin
                    y = int'(start_row) + n - 1;
                    x = int'(start_col);
                end
                x = clamp_col_high(x);
                y = clamp_row_high(y);
                if (x < int'(start_col)) x = int'(start_col);
                if (y < int'(start_row)) y = int'(start_row);
                cur_col    = to_coord(x);
                cur_row    = to_coord(y);
                held_valid = 0;
                return 0;
            end
            if (b == CHAR_SEMI) begin
                if (held_valid) sgr_update(held_param);
                held_param = number;
                held_valid = 1;
                number     = 0;
                phase      = PH_NUM;
                return 0;
            end
            if (b == CHAR_SGR) begin
                if (held_valid) sgr_update(held_param);
                sgr_update(number);
                return 0;
            end
            return plain(b, r);
        endfunction

        function bit predict(input logic [7:0] b, input logic f, output res_t r);
            bit               digit;
            longint unsigned  v;
            digit = (b >= CHAR_ZERO && b <= CHAR_NINE);
            r     = '0;
            if (f) restart();
            case (phase)
                PH_TEXT: begin
                    if (b == CHAR_ESC) begin
                        phase = PH_ESC;
                        return 0;
                    end
                    return plain(b, r);
                end
                PH_ESC: begin
                    if (b == CHAR_LBRACK) begin
                        phase      = PH_CSI;
                        held_valid = 0;
                        held_param = 0;
                        number     = 0;
                        return 0;
                    end
                    return plain(b, r);
                end
                PH_CSI: begin
                    phase = PH_TEXT;
                    if (b == CHAR_SAVE) begin
                        sav_col = cur_col;
                        sav_row = cur_row;
                        return 0;
                    end
                    if (b == CHAR_REST) begin
                        cur_col = sav_col;
                        cur_row = sav_row;
                        return 0;
                    end
                    if (b == CHAR_ERASE) return 0;
                    if (b == CHAR_UP || b == CHAR_DOWN || b == CHAR_RIGHT || b == CHAR_LEFT) begin
                        move_cursor(b, 1);
                        return 0;
                    end
                    if (b == CHAR_HOME) begin
                        cur_col = to_coord(int'(start_col));
                        cur_row = to_coord(int'(start_row));
                        return 0;
                    end
                    if (digit) begin
                        number = b - CHAR_ZERO;
                        phase  = PH_NUM;
                        return 0;
                    end
                    return plain(b, r);
                end
                PH_NUM: begin
                    if (digit) begin
                        v = longint'(number) * 10 + (b - CHAR_ZERO);
                        number = (v > (1 << NUMBER_BITS_DEF) - 1) ?
                                 (1 << NUMBER_BITS_DEF) - 1 : int'(v);
                        return 0;
                    end
                    return end_number(b, r);
                end
                PH_STOP: return 0;
                default: begin
                    phase = PH_TEXT;
                    return 0;
                end
            endcase
        endfunction

        function void note_byte(input logic [7:0] b, input logic f);
            res_t r;
            if (predict(b, f, r)) pending_cells.push_back(r);
        endfunction

        function void compare_field(input string what, input logic [11:0] want,
                                    input logic [11:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_cell(input logic kind, input logic [OUT_DATA_W-1:0] data);
            res_t want;
            if (pending_cells.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual kind %0h data %h",
                         $time, kind, data);
                errors++;
                return;
            end
            want = pending_cells.pop_front();
            compare_field("kind", {11'd0, want.kind}, {11'd0, kind});
            compare_field("cell_col", want.cell_col, data[11:0]);
            compare_field("cell_row", want.cell_row, data[23:12]);
            compare_field("symbol", {4'd0, want.symbol}, {4'd0, data[31:24]});
            compare_field("attribute", {4'd0, want.attribute}, {4'd0, data[39:32]});
        endfunction
    endclass

endpackage

// ----- bench/tb.sv -----
// top of the ansi text importer bench: clock, reset, apb setup, byte stream stimulus
// with random gaps and stalls on both sides; depends on aeti_pkg and aeti_tb_pkg
`timescale 1ns / 100ps

module tb;
    import aeti_pkg::*;
    import aeti_tb_pkg::*;

    localparam int SETTLE = 8;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;   // byte_in
    logic                  s_tuser  = 1'b0; // first
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // cell_col, cell_row, symbol, attribute
    logic                  m_tuser;         // kind

    cell_write_tracker cells = new();

    int bytes_sent   = 0;
    bit next_first   = 1'b0;
    bit random_marks = 1'b0;
    bit send_calm    = 1'b0;
    int stall_left   = 0;
    int calm_left    = 0;

    ansi_escape_text_importer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) cells.check_cell(m_tuser, m_tdata);
            if (s_tvalid && s_tready) cells.note_byte(s_tdata, s_tuser);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // receiver stalls
    initial begin
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (calm_left > 0) calm_left--;
                else if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(50, 200);
                else stall_left = pick_gap();
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic f);
        int gap;
        gap = send_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= f;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_txt(input logic [7:0] b);
        logic f;
        f = next_first | (random_marks && $urandom_range(0, 79) == 0);
        next_first = 1'b0;
        bytes_sent++;
        send_byte(b, f);
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) send_txt(s[i]);
    endtask

    task automatic send_number(input int unsigned v);
        send_str($sformatf("%0d", v));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (cells.pending_cells.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] val);
        logic [APB_DATA_W-1:0] want;
        logic [APB_DATA_W-1:0] got;
        if (idx == REG_START_COL || idx == REG_START_ROW) want = val & ((1 << CFG_COORD_W) - 1);
        else want = val & ((1 << CFG_SIZE_W) - 1);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cells.set_reg(idx, val);
        @(negedge aclk);
        psel <= 1'b1;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        if (got !== want) begin
            $display("%0t: register %0d readback mismatch, expected %0h, actual %0h",
                     $time, idx, want, got);
            cells.errors++;
        end
    endtask

    task automatic configure(input int unsigned sc, input int unsigned sr,
                             input int unsigned bw, input int unsigned bh);
        drain();
        write_reg(REG_START_COL, sc);
        write_reg(REG_START_ROW, sr);
        write_reg(REG_BOARD_WIDTH, bw);
        write_reg(REG_BOARD_HEIGHT, bh);
    endtask

    function automatic int unsigned pick_number();
        case ($urandom_range(0, 7))
            0, 1:    return $urandom_range(0, 9);
            2, 3:    return $urandom_range(1, 30);
            4:       return $urandom_range(30, 47);
            5:       return $urandom_range(0, 4200);
            6:       return $urandom_range(65530, 99999999);
            default: return $urandom;
        endcase
    endfunction

    function automatic int unsigned pick_colour();
        case ($urandom_range(0, 8))
            0:       return SGR_RESET;
            1:       return SGR_BRIGHT;
            2:       return SGR_BLINK;
            3, 4:    return $urandom_range(SGR_FG_LO, SGR_FG_HI);
            5, 6:    return $urandom_range(SGR_BG_LO, SGR_BG_HI);
            7:       return $urandom_range(0, 99);
            default: return pick_number();
        endcase
    endfunction

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 8))
            0:       return CHAR_SAVE;
            1:       return CHAR_REST;
            2:       return CHAR_ERASE;
            3:       return CHAR_UP;
            4:       return CHAR_DOWN;
            5:       return CHAR_RIGHT;
            6:       return CHAR_LEFT;
            7:       return CHAR_HOME;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_term();
        case ($urandom_range(0, 9))
            0:       return CHAR_UP;
            1:       return CHAR_DOWN;
            2:       return CHAR_RIGHT;
            3:       return CHAR_LEFT;
            4:       return CHAR_HOME;
            5:       return CHAR_ERASE;
            6:       return CHAR_CLEAR;
            7:       return CHAR_SGR;
            8:       return CHAR_SEMI;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_chunk();
        int          r;
        int          n;
        logic [7:0]  term;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            n = $urandom_range(1, 8);
            repeat (n) begin
                if ($urandom_range(0, 9) < 7) send_txt(8'($urandom_range(32, 126)));
                else send_txt(8'($urandom_range(0, 255)));
            end
        end else if (r < 35) begin
            case ($urandom_range(0, 2))
                0: send_txt(CHAR_CR);
                1: send_txt(CHAR_LF);
                default: begin
                    send_txt(CHAR_CR);
                    send_txt(CHAR_LF);
                end
            endcase
        end else if (r < 45) begin
            send_txt(CHAR_ESC);
            send_txt(CHAR_LBRACK);
            send_txt(pick_letter());
        end else if (r < 65) begin
            term = pick_term();
            send_txt(CHAR_ESC);
            send_txt(CHAR_LBRACK);
            if (term == CHAR_CLEAR && $urandom_range(0, 4) < 3) send_number(CLEAR_ALL);
            else send_number(pick_number());
            send_txt(term);
        end else if (r < 80) begin
            // row;col positioning, sometimes with empty numbers
            send_txt(CHAR_ESC);
            send_txt(CHAR_LBRACK);
            if ($urandom_range(0, 5) != 0) send_number($urandom_range(0, 3) == 0 ?
                                                       pick_number() : $urandom_range(0, 40));
            send_txt(CHAR_SEMI);
            if ($urandom_range(0, 4) != 0) send_number($urandom_range(0, 3) == 0 ?
                                                       pick_number() : $urandom_range(0, 90));
            send_txt($urandom_range(0, 9) < 8 ? CHAR_HOME : pick_term());
        end else if (r < 92) begin
            send_txt(CHAR_ESC);
            send_txt(CHAR_LBRACK);
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                if (i > 0) send_txt(CHAR_SEMI);
                if ($urandom_range(0, 7) != 0) send_number(pick_colour());
            end
            send_txt(CHAR_SGR);
        end else begin
            case ($urandom_range(0, 2))
                0: begin
                    send_txt(CHAR_ESC);
                    send_txt($urandom_range(0, 3) == 0 ? CHAR_ESC : 8'($urandom_range(0, 255)));
                end
                1: repeat ($urandom_range(1, 4)) send_txt(8'($urandom_range(0, 255)));
                default: begin
                    send_txt(CHAR_ESC);
                    send_txt(CHAR_LBRACK);
                    send_number(pick_number());
                    send_txt(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    task automatic random_run(input int count);
        int target;
        target = bytes_sent + count;
        random_marks = 1'b1;
        while (bytes_sent < target) begin
            send_calm = ($urandom_range(0, 9) == 0);
            if (cells.phase == PH_STOP) begin
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
                next_first = 1'b1;
            end
            send_chunk();
        end
        send_calm = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: field extremes, cr/lf, lone escape, positioning, colours, stop
        next_first = 1'b1;
        send_txt("A");
        send_txt(8'hFF);
        send_txt(8'h00);
        send_txt(CHAR_CR);
        send_txt(CHAR_LF);
        send_txt(CHAR_ESC);
        send_txt(CHAR_ESC);
        send_txt(CHAR_ESC);
        send_str("[5;3H");
        send_txt(CHAR_ESC);
        send_str("[31;1m");
        send_txt(CHAR_ESC);
        send_str("[0J");
        send_txt("q");
        next_first = 1'b1;
        send_txt("z");

        random_run(70);
        configure(4095, 4095, 4096, 4096);
        random_run(55);
        configure(0, 0, 0, 0);
        random_run(50);
        configure(10, 3, 8191, 8191);
        random_run(60);
        configure(4000, 4090, 4096, 4096);
        random_run(55);
        configure($urandom_range(0, 300), $urandom_range(0, 100),
                  $urandom_range(1, 400), $urandom_range(1, 60));
        random_run(70);
        configure(5, 2, 40, 12);
        random_run(70);

        drain();
        if (cells.errors == 0 && cells.pending_cells.size() == 0) begin
            $display("PASS ansi_escape_text_importer");
        end else begin
            $display("FAIL ansi_escape_text_importer");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL ansi_escape_text_importer");
        $finish;
    end

endmodule
